// ===== rtl/asla_pkg.sv =====
// Shared types and constants for the ANSI-stripping line assembler.
`default_nettype none
package asla_pkg;

   localparam int LINE_LIMIT = 512;
   localparam int CNT_W      = $clog2(LINE_LIMIT + 1);

   localparam int OPQ_PTR_W  = 1;
   localparam int OPQ_DEPTH  = 2 ** OPQ_PTR_W;
   localparam int RSPQ_PTR_W = 1;
   localparam int RSPQ_DEPTH = 2 ** RSPQ_PTR_W;

   localparam logic [7:0] ESC_CODE = 8'h1B;
   localparam logic [7:0] BEL_CODE = 8'h07;
   localparam logic [7:0] FINAL_LO = 8'h40;
   localparam logic [7:0] FINAL_HI = 8'h7E;
   localparam logic [7:0] CTRL_TOP = 8'h20;
   localparam logic [7:0] HIGH_LO  = 8'h80;
   localparam logic [7:0] TAB_CODE = 8'h09;
   localparam logic [7:0] LF_CODE  = 8'h0A;
   localparam logic [7:0] CR_CODE  = 8'h0D;
   localparam logic [7:0] CSI_CODE = 8'h5B;
   localparam logic [7:0] OSC_CODE = 8'h5D;
   localparam logic [7:0] ST_CODE  = 8'h5C;

   localparam logic [2:0]  DEFAULT_LEVEL_RESET = 3'd4;
   localparam logic [31:0] SEQ_RESET           = 32'd1;

   localparam logic       CMD_FEED  = 1'b0;
   localparam logic       CMD_FLUSH = 1'b1;
   localparam logic       KIND_CHAR = 1'b0;
   localparam logic       KIND_END  = 1'b1;
   localparam logic [0:0] REG_DEFAULT_LEVEL = 1'b0;

   typedef enum logic {
      OP_CHAR  = 1'b0,
      OP_FLUSH = 1'b1
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  ch;
      logic [2:0]  level;
   } op_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  char_out;
      logic [8:0]  char_index;
      logic [2:0]  record_level;
      logic [31:0] record_seq;
      logic [9:0]  record_length;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]  line_count;
      logic [RSPQ_PTR_W:0] rsp_count;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/ansi_stripping_line_assembler.sv =====
// Top level: console byte stream to kept characters and end-of-record beats.
// A kept byte or record end is registered in the operation queue, then in the
// result queue. Throughput: one input beat per cycle while req_full is low;
// the escape filter and line counter are registered; both queues sustain one beat a cycle.
// Reset (synchronous): queues empty, no escape, line empty, level 4,
// next record number 1, default_level 4.
`default_nettype none
module ansi_stripping_line_assembler (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_push,
   output      logic        req_full,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_byte_in,
   input  wire logic [3:0]  req_level_in,

   output      logic        rsp_empty,
   input  wire logic        rsp_pop,
   output      logic        rsp_out_kind,
   output      logic [7:0]  rsp_char_out,
   output      logic [8:0]  rsp_char_index,
   output      logic [2:0]  rsp_record_level,
   output      logic [31:0] rsp_record_seq,
   output      logic [9:0]  rsp_record_length,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   logic [2:0]           default_level_ff;
   logic                 accept, op_push, op_full, op_empty, op_pop;
   asla_pkg::op_type     op_in, op_head;
   asla_pkg::rsp_type    rsp_head;
   asla_pkg::status_type status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == asla_pkg::REG_DEFAULT_LEVEL) ?
                       {29'b0, default_level_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_level_ff <= asla_pkg::DEFAULT_LEVEL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == asla_pkg::REG_DEFAULT_LEVEL) begin
         default_level_ff <= csr_pwdata[2:0];
      end
   end

   assign req_full = op_full;
   assign accept   = req_push && !op_full;

   asla_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_command),
      .byte_in       (req_byte_in),
      .level_in      (req_level_in),
      .default_level (default_level_ff),
      .op_push       (op_push),
      .op            (op_in)
   );

   asla_op_queue u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (op_push),
      .push_op (op_in),
      .full    (op_full),
      .pop     (op_pop),
      .empty   (op_empty),
      .head    (op_head)
   );

   asla_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (!op_empty),
      .op        (op_head),
      .op_pop    (op_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_head  (rsp_head),
      .status    (status)
   );

   assign rsp_out_kind      = rsp_head.out_kind;
   assign rsp_char_out      = rsp_head.char_out;
   assign rsp_char_index    = rsp_head.char_index;
   assign rsp_record_level  = rsp_head.record_level;
   assign rsp_record_seq    = rsp_head.record_seq;
   assign rsp_record_length = rsp_head.record_length;

   a_line_limit: assert property (@(posedge clock) disable iff (reset)
      status.line_count <= asla_pkg::CNT_W'(asla_pkg::LINE_LIMIT))
      else $error("line count beyond limit");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      status.rsp_count <= (asla_pkg::RSPQ_PTR_W + 1)'(asla_pkg::RSPQ_DEPTH))
      else $error("result queue overfilled");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_kind == asla_pkg::KIND_CHAR) |->
      (rsp_record_seq == 32'd0 && rsp_record_length == 10'd0))
      else $error("character beat carries record fields");

   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op_head.kind == asla_pkg::OP_FLUSH) |=> (status.line_count == '0))
      else $error("line not cleared by flush");

endmodule
`default_nettype wire

// ===== rtl/asla_front.sv =====
// Front end: escape filter and byte classification into line operations.
`default_nettype none
module asla_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              command,
   input  wire logic [7:0]        byte_in,
   input  wire logic [3:0]        level_in,
   input  wire logic [2:0]        default_level,
   output      logic              op_push,
   output      asla_pkg::op_type  op
);

   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_SEEN = 2'd1,
      ESC_BODY = 2'd2,
      ESC_BODY_ESC = 2'd3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] level;
   logic       want;

   assign level = level_in[3] ? default_level : level_in[2:0];

   always_comb begin
      phase_in = phase_ff;
      want     = 1'b0;
      op.kind  = asla_pkg::OP_CHAR;
      op.ch    = byte_in;
      op.level = level;
      if (command == asla_pkg::CMD_FLUSH) begin
         want    = 1'b1;
         op.kind = asla_pkg::OP_FLUSH;
      end else begin
         case (phase_ff)
            ESC_SEEN: begin
               if (byte_in == asla_pkg::CSI_CODE || byte_in == asla_pkg::OSC_CODE)
                  phase_in = ESC_BODY;
               else if (byte_in != asla_pkg::ESC_CODE)
                  phase_in = ESC_IDLE;
            end
            ESC_BODY: begin
               if (byte_in == asla_pkg::BEL_CODE ||
                   byte_in inside {[asla_pkg::FINAL_LO:asla_pkg::FINAL_HI]})
                  phase_in = ESC_IDLE;
               else if (byte_in == asla_pkg::ESC_CODE)
                  phase_in = ESC_BODY_ESC;
            end
            ESC_BODY_ESC: begin
               phase_in = (byte_in == asla_pkg::ST_CODE) ? ESC_IDLE : ESC_BODY;
            end
            default: begin
               if (byte_in == asla_pkg::ESC_CODE) begin
                  phase_in = ESC_SEEN;
               end else if (byte_in == asla_pkg::CR_CODE) begin
                  want = 1'b0;
               end else if (byte_in == asla_pkg::LF_CODE) begin
                  want    = 1'b1;
                  op.kind = asla_pkg::OP_FLUSH;
               end else if ((byte_in < asla_pkg::CTRL_TOP || byte_in >= asla_pkg::HIGH_LO) &&
                            byte_in != asla_pkg::TAB_CODE) begin
                  want = 1'b0;
               end else begin
                  want = 1'b1;
               end
            end
         endcase
      end
   end

   assign op_push = accept && want;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ESC_IDLE;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/asla_op_queue.sv =====
// Short queue of line operations between front and back end.
`default_nettype none
module asla_op_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire asla_pkg::op_type push_op,
   output      logic             full,
   input  wire logic             pop,
   output      logic             empty,
   output      asla_pkg::op_type head
);

   asla_pkg::op_type                entry_ff [asla_pkg::OPQ_DEPTH];
   logic [asla_pkg::OPQ_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [asla_pkg::OPQ_PTR_W:0]    count_ff;
   logic                            do_push, do_pop;

   assign full    = (count_ff == (asla_pkg::OPQ_PTR_W + 1)'(asla_pkg::OPQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)
            count_ff <= count_ff + (asla_pkg::OPQ_PTR_W + 1)'(1);
         else if (do_pop && !do_push)
            count_ff <= count_ff - (asla_pkg::OPQ_PTR_W + 1)'(1);
      end
   end

endmodule
`default_nettype wire

// ===== rtl/asla_back.sv =====
// Back end: line state, record numbering and the result queue.
`default_nettype none
module asla_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                op_valid,
   input  wire asla_pkg::op_type    op,
   output      logic                op_pop,
   input  wire logic                rsp_pop,
   output      logic                rsp_empty,
   output      asla_pkg::rsp_type   rsp_head,
   output      asla_pkg::status_type status
);

   localparam int CW = asla_pkg::CNT_W;

   logic [CW-1:0]   line_count_ff, line_count_in;
   logic [2:0]      line_level_ff, line_level_in;
   logic [31:0]     next_seq_ff, next_seq_in;

   asla_pkg::rsp_type                entry_ff [asla_pkg::RSPQ_DEPTH];
   logic [asla_pkg::RSPQ_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [asla_pkg::RSPQ_PTR_W:0]    count_ff;

   asla_pkg::rsp_type rsp_new;
   logic              produce, rsp_full, do_push, do_pop;
   logic [CW+9:0]     count_ext;
   logic [2:0]        cur_level;

   assign rsp_full  = (count_ff == (asla_pkg::RSPQ_PTR_W + 1)'(asla_pkg::RSPQ_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign count_ext = {10'b0, line_count_ff};
   assign cur_level = (line_count_ff == '0) ? op.level : line_level_ff;

   always_comb begin
      produce       = 1'b0;
      line_count_in = line_count_ff;
      line_level_in = line_level_ff;
      next_seq_in   = next_seq_ff;
      rsp_new       = '0;
      if (op.kind == asla_pkg::OP_FLUSH) begin
         rsp_new.out_kind      = asla_pkg::KIND_END;
         rsp_new.record_level  = line_level_ff;
         rsp_new.record_seq    = next_seq_ff;
         rsp_new.record_length = count_ext[9:0];
         if (line_count_ff != '0) begin
            produce       = 1'b1;
            line_count_in = '0;
            next_seq_in   = next_seq_ff + 32'd1;
         end
      end else begin
         line_level_in        = cur_level;
         rsp_new.out_kind     = asla_pkg::KIND_CHAR;
         rsp_new.char_out     = op.ch;
         rsp_new.char_index   = count_ext[8:0];
         rsp_new.record_level = cur_level;
         if (line_count_ff < CW'(asla_pkg::LINE_LIMIT)) begin
            produce       = 1'b1;
            line_count_in = line_count_ff + CW'(1);
         end
      end
   end

   assign op_pop  = op_valid && (!produce || !rsp_full);
   assign do_push = op_pop && produce;
   assign do_pop  = rsp_pop && !rsp_empty;
   assign rsp_head = entry_ff[rd_ptr_ff];

   assign status.line_count = line_count_ff;
   assign status.rsp_count  = count_ff;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
         line_level_ff <= asla_pkg::DEFAULT_LEVEL_RESET;
         next_seq_ff   <= asla_pkg::SEQ_RESET;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (op_pop) begin
            line_count_ff <= line_count_in;
            line_level_ff <= line_level_in;
            next_seq_ff   <= next_seq_in;
         end
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)
            count_ff <= count_ff + (asla_pkg::RSPQ_PTR_W + 1)'(1);
         else if (do_pop && !do_push)
            count_ff <= count_ff - (asla_pkg::RSPQ_PTR_W + 1)'(1);
      end
   end

endmodule
`default_nettype wire
